[src/lgag_pkg.sv]
package lgag_pkg;

  // Gait geometry
  localparam int PHASE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int LEG_COUNT        = 4;
  localparam int MODE_COUNT       = 8;

  localparam int SINE_DEPTH_LOG = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_IDX_BITS  = SINE_DEPTH_LOG + 1;
  localparam int SINE_FRAC      = 15;
  localparam int SINE_W         = SINE_FRAC + 1;
  localparam int LEG_W          = $clog2(LEG_COUNT);
  localparam int SEL_W          = LEG_W + 1;

  // Shared multiplier and datapath widths
  localparam int MUL_A_W = 12;
  localparam int MUL_B_W = (PHASE_BITS > SINE_W) ? PHASE_BITS : SINE_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
  localparam int NUM_W   = MUL_P_W + 1;
  localparam int OFF_W   = 11;
  localparam int QUO_W   = 11;

  // floor(m / 3) = (m * 683) >> 11 for m below 2046
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  localparam int                  ANGLE_W   = 10;
  localparam logic signed [QUO_W:0] ANGLE_MIN = -(QUO_W+1)'(90);
  localparam logic signed [QUO_W:0] ANGLE_MAX = (QUO_W+1)'(270);

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_SWING  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIFT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FRONT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REAR   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PHASE  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TICK   = 3'd6;

  // Sign codes
  localparam logic signed [1:0] SGN_POS  = 2'sb01;
  localparam logic signed [1:0] SGN_NEG  = 2'sb11;
  localparam logic signed [1:0] SGN_ZERO = 2'sb00;

  typedef struct packed {
    logic signed [1:0] amp_sign;
    logic [7:0]        base;
    logic signed [1:0] half_a;
    logic signed [1:0] f_sign;
    logic signed [1:0] r_sign;
    logic [1:0]        quarters;
  } leg_setup_t;

  localparam leg_setup_t MODE_TAB [0:MODE_COUNT-1][0:LEG_COUNT-1] = '{
    '{ '{SGN_NEG, 8'd90, SGN_ZERO, SGN_NEG, SGN_ZERO, 2'd0},
       '{SGN_POS, 8'd90, SGN_ZERO, SGN_POS, SGN_ZERO, 2'd2},
       '{SGN_NEG, 8'd90, SGN_ZERO, SGN_ZERO, SGN_POS, 2'd1},
       '{SGN_POS, 8'd90, SGN_ZERO, SGN_ZERO, SGN_NEG, 2'd3} },
    '{ '{SGN_POS, 8'd90, SGN_ZERO, SGN_ZERO, SGN_NEG, 2'd1},
       '{SGN_NEG, 8'd90, SGN_ZERO, SGN_ZERO, SGN_POS, 2'd3},
       '{SGN_POS, 8'd90, SGN_ZERO, SGN_POS, SGN_ZERO, 2'd0},
       '{SGN_NEG, 8'd90, SGN_ZERO, SGN_NEG, SGN_ZERO, 2'd2} },
    '{ '{SGN_NEG, 8'd45,  SGN_POS, SGN_ZERO, SGN_ZERO, 2'd0},
       '{SGN_NEG, 8'd135, SGN_POS, SGN_ZERO, SGN_ZERO, 2'd2},
       '{SGN_NEG, 8'd135, SGN_POS, SGN_ZERO, SGN_ZERO, 2'd1},
       '{SGN_NEG, 8'd45,  SGN_POS, SGN_ZERO, SGN_ZERO, 2'd3} },
    '{ '{SGN_POS, 8'd45,  SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd0},
       '{SGN_POS, 8'd135, SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd2},
       '{SGN_POS, 8'd135, SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd1},
       '{SGN_POS, 8'd45,  SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd3} },
    '{ '{SGN_NEG, 8'd45,  SGN_POS, SGN_ZERO, SGN_ZERO, 2'd2},
       '{SGN_POS, 8'd135, SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd0},
       '{SGN_NEG, 8'd135, SGN_POS, SGN_ZERO, SGN_ZERO, 2'd0},
       '{SGN_POS, 8'd45,  SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd2} },
    '{ '{SGN_POS, 8'd45,  SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd2},
       '{SGN_NEG, 8'd135, SGN_POS, SGN_ZERO, SGN_ZERO, 2'd0},
       '{SGN_POS, 8'd135, SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd0},
       '{SGN_NEG, 8'd45,  SGN_POS, SGN_ZERO, SGN_ZERO, 2'd2} },
    '{ '{SGN_POS, 8'd45,  SGN_POS, SGN_ZERO, SGN_ZERO, 2'd2},
       '{SGN_POS, 8'd135, SGN_POS, SGN_ZERO, SGN_ZERO, 2'd0},
       '{SGN_POS, 8'd135, SGN_POS, SGN_ZERO, SGN_ZERO, 2'd0},
       '{SGN_POS, 8'd45,  SGN_POS, SGN_ZERO, SGN_ZERO, 2'd2} },
    '{ '{SGN_NEG, 8'd45,  SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd2},
       '{SGN_NEG, 8'd135, SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd0},
       '{SGN_NEG, 8'd135, SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd0},
       '{SGN_NEG, 8'd45,  SGN_NEG, SGN_ZERO, SGN_ZERO, 2'd2} }
  };

  // Legs with negative lift sign; body height sign is the opposite
  localparam logic [LEG_COUNT-1:0] LIFT_NEG = 4'b0110;

  // Quarter-wave sine, unsigned Q1.15, built at elaboration (Taylor series in Q30)
  typedef logic [SINE_W-1:0] sine_t;
  typedef sine_t sine_tab_t [0:SINE_TABLE_DEPTH];
  typedef longint unsigned taylor_div_t [0:6];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam taylor_div_t     TAYLOR_DIV  = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    int              k;
    int              j;
    for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (j = 0; j < 7; j++) begin
        term = (term * x2) >> 30;
        term = term / TAYLOR_DIV[j];
        if ((j % 2) == 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 16384) >>> 15;
      if (sum > 32768) begin
        sum = 32768;
      end
      tab[k] = SINE_W'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Signed code times unsigned 6-bit register
  function automatic logic signed [7:0] sgn_mul(logic signed [1:0] s, logic [5:0] v);
    logic signed [7:0] r;
    case (s)
      SGN_POS: r = $signed({2'b00, v});
      SGN_NEG: r = -$signed({2'b00, v});
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/lgag_mul.sv]
module lgag_mul (
  input  logic                                 clk,
  input  logic signed [lgag_pkg::MUL_A_W-1:0]  mul_a,
  input  logic        [lgag_pkg::MUL_B_W-1:0]  mul_b,
  output logic signed [lgag_pkg::MUL_P_W-1:0]  mul_p
);
  import lgag_pkg::*;

  // signed x unsigned, product registered
  always_ff @(posedge clk) begin
    mul_p <= mul_a * $signed({1'b0, mul_b});
  end

endmodule

[src/legged_gait_angle_generator.sv]
// Sequence: S_IDLE takes an item and S_CHECK tests it; on a tick the eight servos each pass
//   S_LOAD, S_MUL, S_SUM, S_FIN, a swing servo on the linear return also S_DMUL, S_DSUM.
// Throughput: one input item at a time; an early item (no tick) frees the input from S_CHECK.
//   The pace is set by the one shared multiplier, reused for every product and for /3.
// Reset: synchronous, active low; configuration registers return to their default values,
//   last tick time and phase clear, and any pending result is dropped.
module legged_gait_angle_generator (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] now_ms
  input  logic [2:0]  in_tuser,   // [2:0] gait_mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] angle_deg (signed), [15:10] zero
  output logic [3:0]  out_tuser,  // [3:0] servo_number
  output logic        out_tlast,  // last_of_tick
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import lgag_pkg::*;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for an item
  localparam logic [2:0] S_CHECK = 3'd1;  // interval test, phase advance
  localparam logic [2:0] S_LOAD  = 3'd2;  // leg setup, table read, operands
  localparam logic [2:0] S_MUL   = 3'd3;  // amplitude product in flight
  localparam logic [2:0] S_SUM   = 3'd4;  // add offset, scale down
  localparam logic [2:0] S_DMUL  = 3'd5;  // reciprocal product in flight (/3)
  localparam logic [2:0] S_DSUM  = 3'd6;  // take quotient
  localparam logic [2:0] S_FIN   = 3'd7;  // sign, clamp, hand to output register

  localparam logic [PHASE_BITS-1:0] TWO_Q = PHASE_BITS'(1) << (PHASE_BITS - 1);
  localparam logic [SEL_W-1:0]      SEL_LAST = '1;

  // Configuration registers
  logic [5:0]  swing_r, lift_r, front_r, rear_r, height_r;
  logic [15:0] phase_inc_r, tick_int_r;

  // Tick state
  logic [31:0]           last_tick_r, last_tick_nxt;
  logic [PHASE_BITS-1:0] acc_r, acc_nxt;

  // Sequencer
  logic [2:0]       state_r, state_nxt;
  logic [SEL_W-1:0] sel_r, sel_nxt;

  // Item and working registers (no reset)
  logic [31:0]                now_r, now_nxt;
  logic [2:0]                 mode_r, mode_nxt;
  logic signed [MUL_A_W-1:0]  mul_a_r, mul_a_nxt;
  logic [MUL_B_W-1:0]         mul_b_r, mul_b_nxt;
  logic signed [NUM_W-1:0]    off_r, off_nxt;
  logic                       lin_r, lin_nxt;
  logic                       neg_r, neg_nxt;
  logic [QUO_W-1:0]           quo_r, quo_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic [3:0]               out_sn_r, out_sn_nxt;
  logic [ANGLE_W-1:0]       out_angle_r, out_angle_nxt;
  logic                     out_last_r, out_last_nxt;

  logic signed [MUL_P_W-1:0] mul_p;

  lgag_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a_r),
    .mul_b (mul_b_r),
    .mul_p (mul_p)
  );

  // ---------------------------------------------------------------------------
  // Leg setup for the current servo (used in S_LOAD)
  // ---------------------------------------------------------------------------
  logic [LEG_W-1:0]          leg;
  logic                      axis_z;
  leg_setup_t                st;
  logic [PHASE_BITS-1:0]     p, p2, p_rem, uz, u_sel;
  logic                      early, first_half;
  logic [PHASE_BITS+SINE_DEPTH_LOG-1:0] idx_wide;
  logic [SINE_IDX_BITS-1:0]  sine_idx;
  sine_t                     sine_val;
  logic signed [8:0]         fr_sum;
  logic signed [OFF_W-1:0]   xoff2, zoff2;
  logic signed [7:0]         x_amp, z_amp, h_term;

  always_comb begin
    leg    = sel_r[SEL_W-1:1];
    axis_z = sel_r[0];
    st     = MODE_TAB[mode_r][leg];
    p      = acc_r + {st.quarters, {(PHASE_BITS-2){1'b0}}};
    early  = (p[PHASE_BITS-1:PHASE_BITS-2] == 2'b00);
    // the lift half wave mirrors 2p about a quarter cycle
    first_half = (p[PHASE_BITS-1:PHASE_BITS-3] == 3'b000);
    p2     = {p[PHASE_BITS-2:0], 1'b0};
    uz     = first_half ? p2 : (TWO_Q - p2);
    p_rem  = ~p + 1'b1;  // full cycle minus p
    u_sel  = axis_z ? uz : p;
    idx_wide = {u_sel, {SINE_DEPTH_LOG{1'b0}}} >> (PHASE_BITS - 2);
    sine_idx = idx_wide[SINE_IDX_BITS-1:0];
    sine_val = SINE_TAB[sine_idx];

    x_amp  = sgn_mul(st.amp_sign, swing_r);
    z_amp  = sgn_mul(LIFT_NEG[leg] ? SGN_NEG : SGN_POS, lift_r);
    h_term = sgn_mul(LIFT_NEG[leg] ? SGN_POS : SGN_NEG, height_r);
    fr_sum = 9'(sgn_mul(st.f_sign, front_r)) + 9'(sgn_mul(st.r_sign, rear_r));
    xoff2  = $signed({2'b00, st.base, 1'b0}) + OFF_W'(sgn_mul(st.half_a, swing_r))
             + OFF_W'($signed({fr_sum, 1'b0}));
    zoff2  = OFF_W'(180) + OFF_W'($signed({h_term, 1'b0}));
  end

  // ---------------------------------------------------------------------------
  // Scaling after the product (used in S_SUM)
  // ---------------------------------------------------------------------------
  logic signed [NUM_W-1:0] num_sum;
  logic [NUM_W-1:0]        num_mag, num_shift;
  logic                    num_neg;

  always_comb begin
    num_sum   = off_r + (lin_r ? (NUM_W'(mul_p) <<< 1) : NUM_W'(mul_p));
    num_neg   = num_sum[NUM_W-1];
    num_mag   = num_neg ? NUM_W'(-num_sum) : NUM_W'(num_sum);
    // truncation toward zero: shift the magnitude, sign goes back later
    num_shift = lin_r ? (num_mag >> (PHASE_BITS - 1)) : (num_mag >> SINE_FRAC);
  end

  // ---------------------------------------------------------------------------
  // Sign and clamp (used in S_FIN)
  // ---------------------------------------------------------------------------
  logic signed [QUO_W:0] ang_raw, ang_sat;
  logic                  out_free;

  always_comb begin
    ang_raw = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    if (ang_raw < ANGLE_MIN) begin
      ang_sat = ANGLE_MIN;
    end else if (ang_raw > ANGLE_MAX) begin
      ang_sat = ANGLE_MAX;
    end else begin
      ang_sat = ang_raw;
    end
    out_free = !out_valid_r || out_tready;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    last_tick_nxt = last_tick_r;
    acc_nxt       = acc_r;
    now_nxt       = now_r;
    mode_nxt      = mode_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    off_nxt       = off_r;
    lin_nxt       = lin_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sn_nxt    = out_sn_r;
    out_angle_nxt = out_angle_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          now_nxt   = in_tdata;
          mode_nxt  = in_tuser;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // elapsed time modulo 2^32 against the interval
        if ((now_r - last_tick_r) < {16'd0, tick_int_r}) begin
          state_nxt = S_IDLE;
        end else begin
          last_tick_nxt = now_r;
          acc_nxt       = acc_r + PHASE_BITS'(phase_inc_r);
          sel_nxt       = '0;
          state_nxt     = S_LOAD;
        end
      end
      S_LOAD: begin
        if (axis_z) begin
          mul_a_nxt = MUL_A_W'(z_amp);
          mul_b_nxt = early ? MUL_B_W'(sine_val) : '0;
          off_nxt   = NUM_W'(zoff2) <<< (SINE_FRAC - 1);
          lin_nxt   = 1'b0;
        end else if (early) begin
          mul_a_nxt = MUL_A_W'(x_amp);
          mul_b_nxt = MUL_B_W'(sine_val);
          off_nxt   = NUM_W'(xoff2) <<< (SINE_FRAC - 1);
          lin_nxt   = 1'b0;
        end else begin
          // linear return: xoff2 * 3Q + 2 * xamp * (4Q - p), over 6Q
          mul_a_nxt = MUL_A_W'(x_amp);
          mul_b_nxt = MUL_B_W'(p_rem);
          off_nxt   = (NUM_W'(xoff2) <<< (PHASE_BITS - 1))
                      + (NUM_W'(xoff2) <<< (PHASE_BITS - 2));
          lin_nxt   = 1'b1;
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        neg_nxt = num_neg;
        if (lin_r) begin
          mul_a_nxt = MUL_A_W'({1'b0, num_shift[QUO_W-1:0]});
          mul_b_nxt = MUL_B_W'(DIV3_MUL);
          state_nxt = S_DMUL;
        end else begin
          quo_nxt   = num_shift[QUO_W-1:0];
          state_nxt = S_FIN;
        end
      end
      S_DMUL: begin
        state_nxt = S_DSUM;
      end
      S_DSUM: begin
        quo_nxt   = mul_p[DIV3_SHIFT +: QUO_W];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sn_nxt    = 4'({1'b0, sel_r} + 4'd1);
          out_angle_nxt = ang_sat[ANGLE_W-1:0];
          out_last_nxt  = (sel_r == SEL_LAST);
          sel_nxt       = sel_r + 1'b1;
          state_nxt     = (sel_r == SEL_LAST) ? S_IDLE : S_LOAD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= '0;
      last_tick_r <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      swing_r     <= 6'd20;
      lift_r      <= 6'd20;
      front_r     <= 6'd0;
      rear_r      <= 6'd0;
      height_r    <= 6'd0;
      phase_inc_r <= 16'd3277;
      tick_int_r  <= 16'd50;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      last_tick_r <= last_tick_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SWING:  swing_r     <= cfg_wdata[5:0];
          REG_LIFT:   lift_r      <= cfg_wdata[5:0];
          REG_FRONT:  front_r     <= cfg_wdata[5:0];
          REG_REAR:   rear_r      <= cfg_wdata[5:0];
          REG_HEIGHT: height_r    <= cfg_wdata[5:0];
          REG_PHASE:  phase_inc_r <= cfg_wdata;
          REG_TICK:   tick_int_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    mode_r      <= mode_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    off_r       <= off_nxt;
    lin_r       <= lin_nxt;
    neg_r       <= neg_nxt;
    quo_r       <= quo_nxt;
    out_sn_r    <= out_sn_nxt;
    out_angle_r <= out_angle_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16-ANGLE_W){1'b0}}, out_angle_r};
  assign out_tuser  = out_sn_r;
  assign out_tlast  = out_last_r;

endmodule

[src/lgag_chk.sv]
module lgag_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [15:0] cfg_wdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // tlast marks servo 8 and only servo 8
  a_last_servo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 4'd8)))
    else $error("tlast does not match servo number");

  // a tick part-way through keeps the input closed
  a_mid_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open in the middle of a tick");

  // an accepted item is checked before the next one is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input open the cycle after a transfer");

endmodule

bind legged_gait_angle_generator lgag_chk u_lgag_chk (.*);
